// File: rtl/cfd_pkg.sv
package cfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam logic [BYTE_W-1:0] CODE_DELIM = 8'h00;
  localparam logic [BYTE_W-1:0] CODE_FULL  = 8'hFF;

  typedef enum logic [1:0] {
    KIND_DATA      = 2'd0,
    KIND_END_OK    = 2'd1,
    KIND_END_TRUNC = 2'd2
  } kind_t;

  // one queued command: an optional data beat followed by an optional end beat
  typedef struct packed {
    logic              has_data;
    logic [BYTE_W-1:0] data;
    logic              has_end;
    kind_t             end_kind;
  } cmd_t;

endpackage

// File: rtl/cfd_front.sv
module cfd_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         accept,
  input  logic [cfd_pkg::BYTE_W-1:0]   byte_in,
  input  logic                         last_in,
  output logic                         push,
  output cfd_pkg::cmd_t                cmd
);

  logic [cfd_pkg::BYTE_W-1:0] left_r, left_nxt, left_dec;
  logic                       zp_r, zp_nxt;
  logic                       disc_r, disc_nxt;

  always_comb begin
    push          = 1'b0;
    cmd.has_data  = 1'b0;
    cmd.data      = '0;
    cmd.has_end   = 1'b0;
    cmd.end_kind  = cfd_pkg::KIND_END_OK;
    left_nxt      = left_r;
    zp_nxt        = zp_r;
    disc_nxt      = disc_r;
    left_dec      = left_r - 8'd1;
    if (accept) begin
      if (disc_r) begin
        if (last_in) begin
          disc_nxt = 1'b0;
        end
      end else if (left_r != '0) begin
        cmd.has_data = 1'b1;
        cmd.data     = byte_in;
        left_nxt     = left_dec;
        if (last_in) begin
          cmd.has_end  = 1'b1;
          cmd.end_kind = (left_dec == '0) ? cfd_pkg::KIND_END_OK : cfd_pkg::KIND_END_TRUNC;
          left_nxt     = '0;
          zp_nxt       = 1'b0;
        end
      end else if (byte_in == cfd_pkg::CODE_DELIM) begin
        cmd.has_end  = 1'b1;
        cmd.end_kind = cfd_pkg::KIND_END_OK;
        zp_nxt       = 1'b0;
        disc_nxt     = !last_in;
      end else begin
        cmd.has_data = zp_r;
        left_nxt     = byte_in - 8'd1;
        zp_nxt       = (byte_in != cfd_pkg::CODE_FULL);
        if (last_in) begin
          cmd.has_end  = 1'b1;
          cmd.end_kind = (byte_in == 8'd1) ? cfd_pkg::KIND_END_OK : cfd_pkg::KIND_END_TRUNC;
          left_nxt     = '0;
          zp_nxt       = 1'b0;
        end
      end
      push = cmd.has_data | cmd.has_end;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
      zp_r   <= 1'b0;
      disc_r <= 1'b0;
    end else begin
      left_r <= left_nxt;
      zp_r   <= zp_nxt;
      disc_r <= disc_nxt;
    end
  end

endmodule

// File: rtl/cfd_queue.sv
module cfd_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  cfd_pkg::cmd_t push_cmd,
  output logic          ready,
  input  logic          pop,
  output logic          head_valid,
  output cfd_pkg::cmd_t head_cmd
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cfd_pkg::cmd_t    mem_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign ready      = (cnt_r != CNT_W'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = mem_r[rd_r];
  assign do_push    = push && ready;
  assign do_pop     = pop && head_valid;

  always_comb begin
    wr_nxt  = wr_r;
    rd_nxt  = rd_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wr_nxt = (wr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_r + 1'b1;
    end
    if (do_pop) begin
      rd_nxt = (rd_r == PTR_W'(DEPTH - 1)) ? '0 : rd_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/cfd_back.sv
module cfd_back (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         head_valid,
  input  cfd_pkg::cmd_t                head_cmd,
  output logic                         pop,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [cfd_pkg::BYTE_W-1:0]   out_byte,
  output cfd_pkg::kind_t               out_kind,
  output logic                         out_last
);

  cfd_pkg::cmd_t              cur_r, cur_nxt, src, rest;
  logic                       cur_v_r, cur_v_nxt;
  logic                       src_v, load;
  logic                       ov_r, ov_nxt;
  logic [cfd_pkg::BYTE_W-1:0] ob_r, ob_nxt;
  cfd_pkg::kind_t             ok_r, ok_nxt;
  logic                       ol_r, ol_nxt;

  assign src   = cur_v_r ? cur_r : head_cmd;
  assign src_v = cur_v_r || head_valid;
  assign load  = !ov_r || out_ready;
  assign pop   = load && !cur_v_r && head_valid;

  always_comb begin
    rest          = src;
    rest.has_data = 1'b0;
    cur_nxt       = cur_r;
    cur_v_nxt     = cur_v_r;
    ov_nxt        = ov_r && !out_ready;
    ob_nxt        = ob_r;
    ok_nxt        = ok_r;
    ol_nxt        = ol_r;
    if (load && src_v) begin
      ov_nxt = 1'b1;
      if (src.has_data) begin
        ob_nxt    = src.data;
        ok_nxt    = cfd_pkg::KIND_DATA;
        ol_nxt    = 1'b0;
        cur_v_nxt = src.has_end;
        cur_nxt   = rest;
      end else begin
        ob_nxt    = '0;
        ok_nxt    = src.end_kind;
        ol_nxt    = 1'b1;
        cur_v_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
    ob_r  <= ob_nxt;
    ok_r  <= ok_nxt;
    ol_r  <= ol_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      ov_r    <= ov_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_byte  = ob_r;
  assign out_kind  = ok_r;
  assign out_last  = ol_r;

endmodule

// File: rtl/cobs_frame_decoder.sv
// COBS frame decoder.
// in_*  : one encoded byte per beat; in_tlast marks the last byte of the buffer.
// out_* : decoded beats. out_tuser = 0 for a data byte, 1 for a correct frame
//         end, 2 for a truncated frame end (consumer drops that frame's data).
//         End beats carry out_tlast = 1 and out_tdata = 0.
// Each input byte yields zero, one or two output beats (data, then end).
// The first beat of an input byte is registered in the command queue and then
// in the output register before it is offered on out_*.
// Throughput: one input byte per cycle; output one beat per cycle while
// out_tready is high, so a byte that closes a frame after data takes two
// output beats. Bytes with no result (group codes without pending zero,
// bytes after a delimiter) cost no output slot. The front keeps accepting
// while the queue (QUEUE_DEPTH commands) has room; in_tready drops only when full.
// Reset: decoder state cleared (expects a code byte), queue and output empty.
// Receiver stall: the output beat holds; the queue absorbs new bytes, then
// in_tready falls.
module cobs_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [1:0] out_kind
  output logic       out_tlast
);

  logic           accept, push, q_ready, pop, head_valid;
  cfd_pkg::cmd_t  push_cmd, head_cmd;
  cfd_pkg::kind_t out_kind;

  assign in_tready = q_ready;
  assign accept    = in_tvalid && q_ready;

  cfd_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .byte_in (in_tdata),
    .last_in (in_tlast),
    .push    (push),
    .cmd     (push_cmd)
  );

  cfd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .ready      (q_ready),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  cfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_tdata),
    .out_kind   (out_kind),
    .out_last   (out_tlast)
  );

  assign out_tuser = out_kind;

`ifndef SYNTHESIS
  a_last_kind : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_kind != cfd_pkg::KIND_DATA)))
    else $error("tlast does not match beat kind");

  a_end_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> (out_tdata == 8'd0))
    else $error("end beat carries nonzero data");

  a_push_room : assert property (@(posedge clk) disable iff (!rst_n)
    push |-> q_ready)
    else $error("command pushed into full queue");

  a_pop_load : assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_tvalid)
    else $error("command popped without loading an output beat");
`endif

endmodule

// File: test/cobs_frame_checker.sv
module cobs_frame_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        out_tlast,
  output int unsigned errors,
  output int unsigned pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [7:0]     data;
    cfd_pkg::kind_t kind;
    logic           last;
  } dec_beat_t;

  dec_beat_t   decoded_q[$];
  logic [7:0]  group_left;
  logic        zero_owed;
  logic        skip_to_end;
  int unsigned fail_cnt = 0;
  int unsigned queued_cnt = 0;

  assign errors  = fail_cnt;
  assign pending = queued_cnt;

  function automatic void queue_beat(input logic [7:0] d, input cfd_pkg::kind_t k,
                                     input logic l);
    dec_beat_t e;
    e.data = d;
    e.kind = k;
    e.last = l;
    decoded_q.push_back(e);
  endfunction

  function automatic void clear_frame();
    group_left  = '0;
    zero_owed   = 1'b0;
    skip_to_end = 1'b0;
  endfunction

  function automatic void decode_byte(input logic [7:0] b, input logic l);
    if (skip_to_end) begin
      if (l) clear_frame();
    end else if (group_left != 0) begin
      queue_beat(b, cfd_pkg::KIND_DATA, 1'b0);
      group_left = group_left - 8'd1;
      if (l) begin
        queue_beat(8'h00, (group_left == 0) ? cfd_pkg::KIND_END_OK : cfd_pkg::KIND_END_TRUNC,
                   1'b1);
        clear_frame();
      end
    end else if (b == cfd_pkg::CODE_DELIM) begin
      queue_beat(8'h00, cfd_pkg::KIND_END_OK, 1'b1);
      clear_frame();
      skip_to_end = !l;
    end else begin
      if (zero_owed) queue_beat(8'h00, cfd_pkg::KIND_DATA, 1'b0);
      group_left = b - 8'd1;
      zero_owed  = (b != cfd_pkg::CODE_FULL);
      if (l) begin
        queue_beat(8'h00, (group_left == 0) ? cfd_pkg::KIND_END_OK : cfd_pkg::KIND_END_TRUNC,
                   1'b1);
        clear_frame();
      end
    end
  endfunction

  always @(posedge clk) begin
    dec_beat_t e;
    if (!rst_n) begin
      decoded_q.delete();
      clear_frame();
    end else begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          $display("%0t: unexpected beat: data=%02h kind=%0d last=%0b",
                   $time, out_tdata, out_tuser, out_tlast);
          fail_cnt++;
        end else begin
          e = decoded_q.pop_front();
          if (out_tdata !== e.data || out_tuser !== e.kind || out_tlast !== e.last) begin
            $display({"%0t: beat mismatch: expected data=%02h kind=%0d last=%0b, ",
                      "got data=%02h kind=%0d last=%0b"},
                     $time, e.data, e.kind, e.last, out_tdata, out_tuser, out_tlast);
            fail_cnt++;
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    queued_cnt <= decoded_q.size();
  end

endmodule

// File: test/tb_cobs_frame_decoder.sv
module tb_cobs_frame_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_BEATS  = 425;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        in_tlast;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  int unsigned errors;
  int unsigned pending;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int beats_sent;
  int quiet_cycles   = 0;
  int idle_tab[4]    = '{0, 71, 0, 37};
  int stall_tab[4]   = '{0, 0, 71, 37};

  cobs_frame_decoder DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  cobs_frame_checker frame_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic l);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_buffer(input logic [7:0] bytes[$]);
    foreach (bytes[i]) send_beat(bytes[i], i == bytes.size() - 1);
  endtask

  // builds and sends one buffer: a COBS-encoded frame, mostly well formed
  task automatic send_random_frame();
    logic [7:0] raw[$];
    logic [7:0] enc[$];
    int len;
    int pick;
    int code_at;
    int code;
    pick = $urandom_range(99);
    if (pick < 2)       len = $urandom_range(300, 250);
    else if (pick < 20) len = $urandom_range(40, 13);
    else                len = $urandom_range(12, 0);
    repeat (len) raw.push_back(($urandom_range(9) == 0) ? 8'h00 : 8'($urandom_range(255, 1)));

    code_at = 0;
    code    = 1;
    enc.push_back(8'h00);
    foreach (raw[i]) begin
      if (raw[i] == 8'h00) begin
        enc[code_at] = 8'(code);
        code_at = enc.size();
        enc.push_back(8'h00);
        code = 1;
      end else begin
        enc.push_back(raw[i]);
        code++;
        if (code == 255) begin
          enc[code_at] = 8'(code);
          code_at = enc.size();
          enc.push_back(8'h00);
          code = 1;
        end
      end
    end
    enc[code_at] = 8'(code);

    pick = $urandom_range(99);
    if (pick < 60) begin
      enc.push_back(cfd_pkg::CODE_DELIM);
      beats_sent += enc.size();
    end else if (pick < 70) begin
      beats_sent += enc.size();
    end else if (pick < 80) begin
      enc.push_back(cfd_pkg::CODE_DELIM);
      beats_sent += enc.size();
      repeat ($urandom_range(4, 1)) enc.push_back(8'($urandom_range(255)));
    end else if (pick < 90) begin
      enc = enc[0:$urandom_range(enc.size(), 1) - 1];
      beats_sent += enc.size();
    end else begin
      enc.delete();
      repeat ($urandom_range(8, 1)) enc.push_back(8'($urandom_range(255)));
      beats_sent += enc.size();
    end
    send_buffer(enc);
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    in_tlast  = 1'b0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_buffer('{8'h00});
    send_buffer('{8'h01});
    send_buffer('{8'h05});
    send_buffer('{8'h01, 8'h00});
    send_buffer('{8'h03, 8'h11, 8'h22, 8'h02, 8'h33, 8'h00});
    send_buffer('{8'h03, 8'h12});
    send_buffer('{8'h03, 8'hFF, 8'h00, 8'h01, 8'h00});
    send_buffer('{8'h02, 8'hAA, 8'h00, 8'h55, 8'h66});
    send_buffer('{8'hFF});
    send_buffer('{8'h02, 8'h7F, 8'h01});

    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_tab[ph];
      recv_stall_pct = stall_tab[ph];
      beats_sent     = 0;
      while (beats_sent < PHASE_BEATS) send_random_frame();
    end
    in_tvalid <= 1'b0;
    recv_stall_pct = 0;

    while (pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
